>>> rtl/thread_group_partition_unit_defines.svh
// Assertion macros for the thread group partition unit.
`ifndef THREAD_GROUP_PARTITION_UNIT_DEFINES_SVH
`define THREAD_GROUP_PARTITION_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, off during reset.
`define TGPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tgpu assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TGPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tgpu assertion failed");

`else

`define TGPU_ASSERT_IMP(lbl, ante, cons)
`define TGPU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/tgp_pkg.sv
// Shared widths, codes and stage payload types of the thread group partition unit.
`default_nettype none

package tgp_pkg;

	localparam int OP_W  = 3;
	localparam int CNT_W = 11;
	localparam int ID_W  = 10;
	localparam int ST_W  = 2;
	// dividend width: covers (group+1) * thread_count at full field range
	localparam int DVD_W = 2 * CNT_W;

	localparam logic [OP_W-1:0] OP_MAX = 3'd3;

	typedef enum logic [1:0] {
		MODE_EVEN    = 2'd0,
		MODE_CYCLIC  = 2'd1,
		MODE_BCYC    = 2'd2,
		MODE_BLOCKED = 2'd3
	} mode_t;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_MODE = 2'd1;
	localparam logic [ST_W-1:0] ST_DIVZ = 2'd2;

	// how the result of a beat is formed
	typedef enum logic [2:0] {
		KIND_SINGLE = 3'd0,
		KIND_EACH   = 3'd1,
		KIND_MODE   = 3'd2,
		KIND_DIVZ   = 3'd3,
		KIND_NORM   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		mode_t            mode;
		logic [CNT_W-1:0] nt;
		logic [ID_W-1:0]  tid;
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] bs;
	} side_t;

	// after the first divide: quotient and remainder of lane A
	typedef struct packed {
		side_t            base;
		logic [CNT_W-1:0] q1;
		logic [CNT_W-1:0] r1;
	} side2_t;

endpackage

`default_nettype wire

>>> rtl/tgp_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module tgp_div #(
	parameter int DW = tgp_pkg::DVD_W,
	parameter int VW = tgp_pkg::CNT_W,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [SW-1:0] in_side,
	input  logic [DW-1:0] in_dvd_a,
	input  logic [VW-1:0] in_dvs_a,
	input  logic [DW-1:0] in_dvd_b,
	input  logic [VW-1:0] in_dvs_b,
	output logic          out_vld,
	output logic [SW-1:0] out_side,
	output logic [DW-1:0] out_quo_a,
	output logic [VW-1:0] out_rem_a,
	output logic [DW-1:0] out_quo_b
);

	localparam int NL = 2;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic logic [VW+DW-1:0] div_step(
		input logic [VW-1:0] r,
		input logic [DW-1:0] x,
		input logic [VW-1:0] d
	);
		logic [VW:0] t;
		logic        ge;
		t  = {r, x[DW-1]};
		ge = (t >= {1'b0, d});
		if (ge) begin
			t = t - {1'b0, d};
		end
		return {t[VW-1:0], x[DW-2:0], ge};
	endfunction

	logic          vld_s  [DW];
	logic [SW-1:0] side_s [DW];
	logic [DW-1:0] num_s  [DW][NL];
	logic [VW-1:0] rem_s  [DW][NL];
	logic [VW-1:0] dvs_s  [DW][NL];

	logic          vld_p  [DW];
	logic [SW-1:0] side_p [DW];
	logic [DW-1:0] num_p  [DW][NL];
	logic [VW-1:0] rem_p  [DW][NL];
	logic [VW-1:0] dvs_p  [DW][NL];

	// stage inputs: beat entering, or previous stage
	always_comb begin
		vld_p[0]    = in_vld;
		side_p[0]   = in_side;
		num_p[0][0] = in_dvd_a;
		num_p[0][1] = in_dvd_b;
		dvs_p[0][0] = in_dvs_a;
		dvs_p[0][1] = in_dvs_b;
		rem_p[0][0] = '0;
		rem_p[0][1] = '0;
		for (int k = 1; k < DW; k++) begin
			vld_p[k]  = vld_s[k-1];
			side_p[k] = side_s[k-1];
			for (int l = 0; l < NL; l++) begin
				num_p[k][l] = num_s[k-1][l];
				rem_p[k][l] = rem_s[k-1][l];
				dvs_p[k][l] = dvs_s[k-1][l];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			for (int k = 0; k < DW; k++) begin
				vld_s[k] <= vld_p[k];
			end
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DW; k++) begin
				side_s[k] <= side_p[k];
				for (int l = 0; l < NL; l++) begin
					{rem_s[k][l], num_s[k][l]} <= div_step(rem_p[k][l], num_p[k][l],
						dvs_p[k][l]);
					dvs_s[k][l] <= dvs_p[k][l];
				end
			end
		end
	end

	assign out_vld   = vld_s[DW-1];
	assign out_side  = side_s[DW-1];
	assign out_quo_a = num_s[DW-1][0];
	assign out_rem_a = rem_s[DW-1][0];
	assign out_quo_b = num_s[DW-1][1];

endmodule

`default_nettype wire

>>> rtl/thread_group_partition_unit.sv
// Top level of the thread group partition unit: decode, two divide passes, post math.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | sink      | in_valid / in_ready  | operation, thread_count, thread_id,
//          |           |                      | group_count, block_size
//  out     | source    | out_valid/ out_ready | group_index, new_thread_id,
//          |           |                      | new_thread_count, group_total, status
//
// One beat per cycle unless the output stalls; the stages are decode, 22-stage divider,
// operand stage, 22-stage divider, three post stages, output register. The two bit-serial
// divider pipelines set the depth. Reset clears the valid bits only. While the
// output holds a beat that is not taken, the whole pipeline holds and in_ready is low.
`default_nettype none

module thread_group_partition_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tgp_pkg::OP_W-1:0]   operation,
	input  logic [tgp_pkg::CNT_W-1:0]  thread_count,
	input  logic [tgp_pkg::ID_W-1:0]   thread_id,
	input  logic [tgp_pkg::CNT_W-1:0]  group_count,
	input  logic [tgp_pkg::CNT_W-1:0]  block_size,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tgp_pkg::ID_W-1:0]   group_index,
	output logic [tgp_pkg::ID_W-1:0]   new_thread_id,
	output logic [tgp_pkg::CNT_W-1:0]  new_thread_count,
	output logic [tgp_pkg::CNT_W-1:0]  group_total,
	output logic [tgp_pkg::ST_W-1:0]   status
);

	import tgp_pkg::*;

`include "thread_group_partition_unit_defines.svh"

	localparam int USED_W = DVD_W + 1;

	logic adv;

	// stage 1
	side_t             side_in;
	logic              vld_s1;
	side_t             side_s1;
	logic [DVD_W-1:0]  prod_s1;
	logic [CNT_W:0]    wsum_s1;

	// divider 1
	logic [DVD_W-1:0]  d1i_dvd_a, d1i_dvd_b;
	logic [CNT_W-1:0]  d1i_dvs_a, d1i_dvs_b;
	logic              d1_vld;
	logic [$bits(side_t)-1:0] d1_side_raw;
	side_t             d1_side;
	logic [DVD_W-1:0]  d1_qa, d1_qb;
	logic [CNT_W-1:0]  d1_ra;

	// stage 2
	side2_t            side2_in;
	logic [DVD_W-1:0]  dvd_a_in2, dvd_b_in2;
	logic [CNT_W-1:0]  dvs_a_in2, dvs_b_in2;
	logic [CNT_W-1:0]  grp_inc2, left2;
	logic              vld_s2;
	side2_t            side_s2;
	logic [DVD_W-1:0]  dvd_a_s2, dvd_b_s2;
	logic [CNT_W-1:0]  dvs_a_s2, dvs_b_s2;

	// divider 2
	logic              d2_vld;
	logic [$bits(side2_t)-1:0] d2_side_raw;
	side2_t            d2_side;
	logic [DVD_W-1:0]  d2_qa, d2_qb;
	logic [CNT_W-1:0]  d2_ra;

	// stage 3
	logic [CNT_W-1:0]  grp3, mfa3, mfb3, rounds3;
	logic [ID_W-1:0]   ntid3;
	logic [CNT_W-1:0]  ncnt3;
	logic [DVD_W-1:0]  mul_a3, mul_rn3, mul_gb3, mul_rb3, tid_x3;
	logic              vld_s3;
	side2_t            side_s3;
	logic [CNT_W-1:0]  grp_s3;
	logic [ID_W-1:0]   ntid_s3;
	logic [CNT_W-1:0]  ncnt_s3;
	logic [DVD_W-1:0]  mul_a_s3, mul_gb_s3, mul_rb_s3;
	logic [CNT_W-1:0]  mul_rn_s3;

	// stage 4
	logic [DVD_W-1:0]  rnb4;
	logic [ID_W-1:0]   ntid4;
	logic [CNT_W-1:0]  ncnt4, left4;
	logic              vld_s4;
	side2_t            side_s4;
	logic [CNT_W-1:0]  grp_s4;
	logic [ID_W-1:0]   ntid_s4;
	logic [CNT_W-1:0]  ncnt_s4;
	logic [DVD_W-1:0]  rnb_s4, gb_s4, rb_s4;

	// stage 5
	logic              vld_s5;
	side2_t            side_s5;
	logic [CNT_W-1:0]  grp_s5;
	logic [ID_W-1:0]   ntid_s5;
	logic [CNT_W-1:0]  ncnt_s5;
	logic [USED_W-1:0] used_s5;
	logic [CNT_W-1:0]  rb_s5;

	// stage 6 (output)
	logic [CNT_W-1:0]  rest6, mn6, ncnt6;
	logic [ID_W-1:0]   gi_nx, nid_nx;
	logic [CNT_W-1:0]  ncnt_nx, gtot_nx;
	logic [ST_W-1:0]   st_nx;
	logic              vld_s6;
	logic [ID_W-1:0]   gi_s6, nid_s6;
	logic [CNT_W-1:0]  ncnt_s6, gtot_s6;
	logic [ST_W-1:0]   st_s6;

	// whole pipeline moves unless the output beat is stuck
	assign adv      = !vld_s6 || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: classify and first products ----------------
	always_comb begin
		side_in.mode = mode_t'(operation[1:0]);
		side_in.nt   = thread_count;
		side_in.tid  = thread_id;
		side_in.n    = group_count;
		side_in.bs   = block_size;
		priority if (group_count == CNT_W'(1)) begin
			side_in.kind = KIND_SINGLE;
		end else if (group_count != '0 && group_count >= thread_count) begin
			side_in.kind = KIND_EACH;
		end else if (operation > OP_MAX) begin
			side_in.kind = KIND_MODE;
		end else if (group_count == '0 ||
			(mode_t'(operation[1:0]) == MODE_BCYC && block_size == '0)) begin
			side_in.kind = KIND_DIVZ;
		end else begin
			side_in.kind = KIND_NORM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			prod_s1 <= DVD_W'(group_count) * DVD_W'(thread_id);
			wsum_s1 <= {1'b0, thread_count} + {1'b0, group_count} - (CNT_W+1)'(1);
		end
	end

	// first divide operands per mode
	always_comb begin
		d1i_dvd_a = DVD_W'(side_s1.tid);
		d1i_dvs_a = side_s1.n;
		d1i_dvd_b = '0;
		d1i_dvs_b = CNT_W'(1);
		unique case (side_s1.mode)
			MODE_EVEN: begin
				d1i_dvd_a = prod_s1;
				d1i_dvs_a = side_s1.nt;
			end
			MODE_CYCLIC: begin
				d1i_dvd_a = DVD_W'(side_s1.tid);
				d1i_dvs_a = side_s1.n;
			end
			MODE_BCYC: begin
				d1i_dvd_a = DVD_W'(side_s1.tid);
				d1i_dvs_a = side_s1.bs;
				d1i_dvd_b = DVD_W'(side_s1.nt);
				d1i_dvs_b = side_s1.bs;
			end
			MODE_BLOCKED: begin
				d1i_dvd_a = DVD_W'(wsum_s1);
				d1i_dvs_a = side_s1.n;
			end
		endcase
	end

	tgp_div #(
		.DW(DVD_W),
		.VW(CNT_W),
		.SW($bits(side_t))
	) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s1),
		.in_side  (side_s1),
		.in_dvd_a (d1i_dvd_a),
		.in_dvs_a (d1i_dvs_a),
		.in_dvd_b (d1i_dvd_b),
		.in_dvs_b (d1i_dvs_b),
		.out_vld  (d1_vld),
		.out_side (d1_side_raw),
		.out_quo_a(d1_qa),
		.out_rem_a(d1_ra),
		.out_quo_b(d1_qb)
	);

	assign d1_side = side_t'(d1_side_raw);

	// ---------------- stage 2: second divide operands ----------------
	always_comb begin
		side2_in.base = d1_side;
		side2_in.q1   = d1_qa[CNT_W-1:0];
		side2_in.r1   = d1_ra;
		grp_inc2      = d1_qa[CNT_W-1:0] + CNT_W'(1);
		left2         = (d1_side.nt > d1_ra) ? (d1_side.nt - d1_ra) : '0;
		dvd_a_in2     = DVD_W'(d1_side.tid);
		dvs_a_in2     = d1_side.n;
		dvd_b_in2     = '0;
		dvs_b_in2     = CNT_W'(1);
		unique case (d1_side.mode)
			MODE_EVEN: begin
				// first and one-past-last thread of the group
				dvd_a_in2 = DVD_W'(d1_qa[CNT_W-1:0]) * DVD_W'(d1_side.nt);
				dvs_a_in2 = d1_side.n;
				dvd_b_in2 = DVD_W'(grp_inc2) * DVD_W'(d1_side.nt);
				dvs_b_in2 = d1_side.n;
			end
			MODE_CYCLIC: begin
				// ceil((nt - grp) / n)
				dvd_a_in2 = DVD_W'(left2) + DVD_W'(d1_side.n) - DVD_W'(1);
				dvs_a_in2 = d1_side.n;
			end
			MODE_BCYC: begin
				// block index over groups, and full rounds
				dvd_a_in2 = DVD_W'(d1_qa[CNT_W-1:0]);
				dvs_a_in2 = d1_side.n;
				dvd_b_in2 = DVD_W'(d1_qb[CNT_W-1:0]);
				dvs_b_in2 = d1_side.n;
			end
			MODE_BLOCKED: begin
				// thread index over group width
				dvd_a_in2 = DVD_W'(d1_side.tid);
				dvs_a_in2 = d1_qa[CNT_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2  <= side2_in;
			dvd_a_s2 <= dvd_a_in2;
			dvs_a_s2 <= dvs_a_in2;
			dvd_b_s2 <= dvd_b_in2;
			dvs_b_s2 <= dvs_b_in2;
		end
	end

	tgp_div #(
		.DW(DVD_W),
		.VW(CNT_W),
		.SW($bits(side2_t))
	) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s2),
		.in_side  (side_s2),
		.in_dvd_a (dvd_a_s2),
		.in_dvs_a (dvs_a_s2),
		.in_dvd_b (dvd_b_s2),
		.in_dvs_b (dvs_b_s2),
		.out_vld  (d2_vld),
		.out_side (d2_side_raw),
		.out_quo_a(d2_qa),
		.out_rem_a(d2_ra),
		.out_quo_b(d2_qb)
	);

	assign d2_side = side2_t'(d2_side_raw);

	// ---------------- stage 3: group index, products ----------------
	always_comb begin
		tid_x3  = DVD_W'(d2_side.base.tid);
		rounds3 = d2_qb[CNT_W-1:0];
		grp3    = '0;
		ntid3   = '0;
		ncnt3   = '0;
		mfa3    = '0;
		mfb3    = '0;
		unique case (d2_side.base.mode)
			MODE_EVEN: begin
				grp3  = d2_side.q1;
				ntid3 = (tid_x3 > d2_qa) ? ID_W'(tid_x3 - d2_qa) : '0;
				ncnt3 = (d2_qb > d2_qa) ? CNT_W'(d2_qb - d2_qa) : '0;
			end
			MODE_CYCLIC: begin
				grp3  = d2_side.r1;
				ntid3 = d2_side.q1[ID_W-1:0];
				ncnt3 = d2_qa[CNT_W-1:0];
			end
			MODE_BCYC: begin
				grp3 = d2_ra;
				mfa3 = d2_qa[CNT_W-1:0];
				mfb3 = d2_side.base.bs;
			end
			MODE_BLOCKED: begin
				grp3 = d2_qa[CNT_W-1:0];
				mfa3 = d2_qa[CNT_W-1:0];
				mfb3 = d2_side.q1;
			end
		endcase
		mul_a3  = DVD_W'(mfa3) * DVD_W'(mfb3);
		mul_rn3 = DVD_W'(rounds3) * DVD_W'(d2_side.base.n);
		mul_gb3 = DVD_W'(d2_ra) * DVD_W'(d2_side.base.bs);
		mul_rb3 = DVD_W'(rounds3) * DVD_W'(d2_side.base.bs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3   <= d2_side;
			grp_s3    <= grp3;
			ntid_s3   <= ntid3;
			ncnt_s3   <= ncnt3;
			mul_a_s3  <= mul_a3;
			mul_rn_s3 <= mul_rn3[CNT_W-1:0];
			mul_gb_s3 <= mul_gb3;
			mul_rb_s3 <= mul_rb3;
		end
	end

	// ---------------- stage 4: index in group, blocked count ----------------
	always_comb begin
		rnb4  = DVD_W'(mul_rn_s3) * DVD_W'(side_s3.base.bs);
		ntid4 = ntid_s3;
		ncnt4 = ncnt_s3;
		left4 = (DVD_W'(side_s3.base.nt) > mul_a_s3) ?
			(side_s3.base.nt - mul_a_s3[CNT_W-1:0]) : '0;
		unique case (side_s3.base.mode)
			MODE_BCYC: begin
				ntid4 = mul_a_s3[ID_W-1:0] + side_s3.r1[ID_W-1:0];
			end
			MODE_BLOCKED: begin
				ntid4 = side_s3.base.tid - mul_a_s3[ID_W-1:0];
				ncnt4 = (side_s3.q1 < left4) ? side_s3.q1 : left4;
			end
			MODE_EVEN, MODE_CYCLIC: begin
				ntid4 = ntid_s3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			grp_s4  <= grp_s3;
			ntid_s4 <= ntid4;
			ncnt_s4 <= ncnt4;
			rnb_s4  <= rnb4;
			gb_s4   <= mul_gb_s3;
			rb_s4   <= mul_rb_s3;
		end
	end

	// ---------------- stage 5: threads used before this group ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			grp_s5  <= grp_s4;
			ntid_s5 <= ntid_s4;
			ncnt_s5 <= ncnt_s4;
			used_s5 <= {1'b0, rnb_s4} + {1'b0, gb_s4};
			rb_s5   <= rb_s4[CNT_W-1:0];
		end
	end

	// ---------------- stage 6: tail of block-cyclic, result select ----------------
	always_comb begin
		rest6 = (USED_W'(side_s5.base.nt) > used_s5) ?
			(side_s5.base.nt - used_s5[CNT_W-1:0]) : '0;
		mn6   = (side_s5.base.bs < rest6) ? side_s5.base.bs : rest6;
		ncnt6 = (side_s5.base.mode == MODE_BCYC) ? (rb_s5 + mn6) : ncnt_s5;
		unique case (side_s5.base.kind)
			KIND_SINGLE: begin
				gi_nx   = '0;
				nid_nx  = side_s5.base.tid;
				ncnt_nx = side_s5.base.nt;
				gtot_nx = CNT_W'(1);
				st_nx   = ST_OK;
			end
			KIND_EACH: begin
				gi_nx   = side_s5.base.tid;
				nid_nx  = '0;
				ncnt_nx = CNT_W'(1);
				gtot_nx = side_s5.base.nt;
				st_nx   = ST_OK;
			end
			KIND_NORM: begin
				gi_nx   = grp_s5[ID_W-1:0];
				nid_nx  = ntid_s5;
				ncnt_nx = ncnt6;
				gtot_nx = side_s5.base.n;
				st_nx   = ST_OK;
			end
			KIND_DIVZ: begin
				gi_nx   = '0;
				nid_nx  = '0;
				ncnt_nx = '0;
				gtot_nx = '0;
				st_nx   = ST_DIVZ;
			end
			default: begin
				gi_nx   = '0;
				nid_nx  = '0;
				ncnt_nx = '0;
				gtot_nx = '0;
				st_nx   = ST_MODE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gi_s6   <= gi_nx;
			nid_s6  <= nid_nx;
			ncnt_s6 <= ncnt_nx;
			gtot_s6 <= gtot_nx;
			st_s6   <= st_nx;
		end
	end

	assign out_valid        = vld_s6;
	assign group_index      = gi_s6;
	assign new_thread_id    = nid_s6;
	assign new_thread_count = ncnt_s6;
	assign group_total      = gtot_s6;
	assign status           = st_s6;

	// ---------------- checks ----------------
	`TGPU_ASSERT_IMP(a_err_fields_zero, out_valid && status != ST_OK, group_index == '0 && new_thread_id == '0 && new_thread_count == '0 && group_total == '0)
	`TGPU_ASSERT_IMP(a_status_known, out_valid, status == ST_OK || status == ST_MODE || status == ST_DIVZ)
	`TGPU_ASSERT_NXT(a_stall_holds_mid, !adv, $stable(vld_s4) && $stable(side_s4) && $stable(ntid_s4))
	`TGPU_ASSERT_NXT(a_stall_holds_out, !adv, $stable(gi_s6) && $stable(ncnt_s6) && $stable(st_s6))

endmodule

`default_nettype wire
